>>> hw/rtl/ghc_pkg.sv
// Shared constants, status codes and the arctangent table for the geofence check.
package ghc_pkg;

  localparam int CW       = 34;
  localparam int RAD_BITS = 31;
  localparam int SQ_BITS  = 31;

  localparam logic signed [CW-1:0] LAT_LIMIT = 34'sd900000000;
  localparam logic signed [CW-1:0] LON_LIMIT = 34'sd1800000000;
  localparam logic signed [CW-1:0] LON_TURN  = 34'sd3600000000;
  localparam logic signed [CW-1:0] INV_GAIN  = 34'sd652032874;
  localparam logic signed [CW-1:0] HALF_PI   = 34'sd1686629713;

  localparam logic [30:0] RAD_MUL   = 31'd1686629713;
  localparam logic [30:0] RAD_BIAS  = 31'd900000000;
  localparam logic [31:0] RAD_RECIP = 32'd2562047788;
  localparam logic [33:0] RAD_DIV_1 = 34'd1800000000;
  localparam logic [33:0] RAD_DIV_2 = 34'd3600000000;
  localparam logic [33:0] RAD_DIV_3 = 34'd5400000000;
  localparam logic [30:0] ONE_Q30   = 31'd1073741824;
  localparam logic [23:0] EARTH_2X  = 24'd12742000;
  localparam logic [24:0] DIST_MAX  = 25'd20015087;
  localparam logic [25:0] RADIUS_RESET = 26'd8000;

  localparam logic [1:0] ST_INSIDE  = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  function automatic logic [30:0] atan_q30(input int i);
    logic [30:0] r;
    case (i)
      0: r = 31'd843314856;
      1: r = 31'd497837829;
      2: r = 31'd263043837;
      3: r = 31'd133525158;
      4: r = 31'd67021686;
      5: r = 31'd33543515;
      6: r = 31'd16775850;
      7: r = 31'd8388437;
      8: r = 31'd4194282;
      9: r = 31'd2097149;
      default: begin
        if (i <= 30) r = 31'((32'd1 << (30 - i)) - 32'd1);
        else r = 31'd0;
      end
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/ghc_in_if.sv
// Input channel carrying one target and site position pair.
interface ghc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] target_lat;
  logic signed [31:0] target_lon;
  logic signed [30:0] site_lat;
  logic signed [31:0] site_lon;
  logic               radius_given;
  logic [25:0]        radius_m;

  modport source (output valid, target_lat, target_lon, site_lat, site_lon,
                  radius_given, radius_m, input ready);
  modport sink (input valid, target_lat, target_lon, site_lat, site_lon,
                radius_given, radius_m, output ready);
endinterface

>>> hw/rtl/ghc_out_if.sv
// Output channel carrying one geofence status and distance.
interface ghc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [24:0] distance_m;

  modport source (output valid, status, distance_m, input ready);
  modport sink (input valid, status, distance_m, output ready);
endinterface

>>> hw/rtl/ghc_div.sv
// Pipelined degree-to-radian scaling by reciprocal multiplication, four register stages.
module ghc_div
  import ghc_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic [RAD_BITS-1:0]  mag,
  input  logic                 neg,
  output logic signed [CW-1:0] rad
);

  logic [61:0]         num1, num2, num3;
  logic [RAD_BITS-1:0] qe2, qe3;
  logic [61:0]         qd3;
  logic                sgn1, sgn2, sgn3;
  logic [62:0]         est;
  logic [61:0]         rem;
  logic [RAD_BITS-1:0] quo;

  always_comb begin
    est = 63'(num1[61:31]) * 63'(RAD_RECIP);
    rem = num3 - qd3;
    quo = qe3 + RAD_BITS'(rem[33:0] >= RAD_DIV_1) + RAD_BITS'(rem[33:0] >= RAD_DIV_2) +
          RAD_BITS'(rem[33:0] >= RAD_DIV_3);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num1 <= 62'(mag) * 62'(RAD_MUL) + 62'(RAD_BIAS);
      sgn1 <= neg;
      num2 <= num1;
      qe2  <= est[61:31];
      sgn2 <= sgn1;
      num3 <= num2;
      qe3  <= qe2;
      qd3  <= 62'(qe2) * 62'(RAD_DIV_1);
      sgn3 <= sgn2;
      if (sgn3) rad <= -$signed({3'b000, quo});
      else rad <= $signed({3'b000, quo});
    end
  end

endmodule

>>> hw/rtl/ghc_cordic.sv
// Pipelined CORDIC, one micro-rotation per stage, rotation or vectoring mode.
module ghc_cordic
  import ghc_pkg::*;
#(
  parameter int STAGES    = 24,
  parameter bit VECTORING = 1'b0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [CW-1:0] z_in,
  output logic signed [CW-1:0] x_out,
  output logic signed [CW-1:0] y_out,
  output logic signed [CW-1:0] z_out
);

  logic signed [CW-1:0] x  [1:STAGES];
  logic signed [CW-1:0] y  [1:STAGES];
  logic signed [CW-1:0] z  [1:STAGES];
  logic signed [CW-1:0] xs [0:STAGES-1];
  logic signed [CW-1:0] ys [0:STAGES-1];
  logic signed [CW-1:0] zs [0:STAGES-1];
  logic signed [CW-1:0] xn [0:STAGES-1];
  logic signed [CW-1:0] yn [0:STAGES-1];
  logic signed [CW-1:0] zn [0:STAGES-1];

  always_comb begin
    xs[0] = x_in;
    ys[0] = y_in;
    zs[0] = z_in;
    for (int i = 1; i < STAGES; i++) begin
      xs[i] = x[i];
      ys[i] = y[i];
      zs[i] = z[i];
    end
    for (int i = 0; i < STAGES; i++) begin
      if (VECTORING ? (ys[i] < 0) : (zs[i] >= 0)) begin
        xn[i] = xs[i] - (ys[i] >>> i);
        yn[i] = ys[i] + (xs[i] >>> i);
        zn[i] = zs[i] - $signed({3'b000, atan_q30(i)});
      end else begin
        xn[i] = xs[i] + (ys[i] >>> i);
        yn[i] = ys[i] - (xs[i] >>> i);
        zn[i] = zs[i] + $signed({3'b000, atan_q30(i)});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < STAGES; i++) begin
        x[i+1] <= xn[i];
        y[i+1] <= yn[i];
        z[i+1] <= zn[i];
      end
    end
  end

  assign x_out = x[STAGES];
  assign y_out = y[STAGES];
  assign z_out = z[STAGES];

endmodule

>>> hw/rtl/ghc_hav.sv
// Haversine term a and its complement 1 - a from the sines and cosines, three register stages.
module ghc_hav
  import ghc_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] sdl,
  input  logic signed [31:0] sdo,
  input  logic signed [31:0] cl1,
  input  logic signed [31:0] cl2,
  output logic [60:0]        va,
  output logic [60:0]        vb
);

  logic signed [63:0] p1, p2, p3, m;
  logic signed [33:0] s1;
  logic signed [31:0] t, u;
  logic signed [34:0] asum;
  logic [30:0]        a;

  assign t = p2[61:30];
  assign u = p3[61:30];

  always_comb begin
    asum = 35'(s1) + 35'($signed(m[63:30]));
    if (asum < 0) a = '0;
    else if (asum > $signed({4'b0000, ONE_Q30})) a = ONE_Q30;
    else a = asum[30:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= sdl * sdl;
      p2 <= cl1 * cl2;
      p3 <= sdo * sdo;
      s1 <= p1[63:30];
      m  <= t * u;
      va <= {a, 30'd0};
      vb <= {ONE_Q30 - a, 30'd0};
    end
  end

endmodule

>>> hw/rtl/ghc_sqrt.sv
// Pipelined restoring square root, one result bit per stage.
module ghc_sqrt
  import ghc_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [60:0]        v,
  output logic [SQ_BITS-1:0] root
);

  logic [61:0] rem   [1:SQ_BITS];
  logic [61:0] rt    [1:SQ_BITS];
  logic [61:0] rs    [0:SQ_BITS-1];
  logic [61:0] ts    [0:SQ_BITS-1];
  logic [61:0] rem_n [0:SQ_BITS-1];
  logic [61:0] rt_n  [0:SQ_BITS-1];

  always_comb begin
    rs[0] = {1'b0, v};
    ts[0] = '0;
    for (int k = 1; k < SQ_BITS; k++) begin
      rs[k] = rem[k];
      ts[k] = rt[k];
    end
    for (int k = 0; k < SQ_BITS; k++) begin
      if (rs[k] >= ts[k] + (62'd1 << (2 * (SQ_BITS - 1 - k)))) begin
        rem_n[k] = rs[k] - (ts[k] + (62'd1 << (2 * (SQ_BITS - 1 - k))));
        rt_n[k]  = (ts[k] >> 1) + (62'd1 << (2 * (SQ_BITS - 1 - k)));
      end else begin
        rem_n[k] = rs[k];
        rt_n[k]  = ts[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQ_BITS; k++) begin
        rem[k+1] <= rem_n[k];
        rt[k+1]  <= rt_n[k];
      end
    end
  end

  assign root = rt[SQ_BITS][SQ_BITS-1:0];

endmodule

>>> hw/rtl/geofence_haversine_check_unit.sv
// Top level of the geofence haversine distance check.
// Throughput: one item per cycle; the radian scaling, sqrt and CORDIC chains are pipelined.
// A stall on the result side freezes the whole pipeline; the input is ready whenever
// the result register is empty or being taken.
// Reset clears all valid bits and sets the default radius to 8000 m.
module geofence_haversine_check_unit
  import ghc_pkg::*;
#(
  parameter int CORDIC_STAGES = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [25:0] cfg_wdata,
  ghc_in_if.sink      request,
  ghc_out_if.source   result
);

  localparam int N = 40 + 2 * CORDIC_STAGES;

  typedef struct packed {
    logic        invalid;
    logic [25:0] radius;
  } side_t;

  logic        en;
  logic [25:0] default_radius;

  logic               p0_vld;
  logic signed [31:0] p0_tlat, p0_tlon, p0_slon;
  logic signed [30:0] p0_slat;
  logic               p0_rgiven;
  logic [25:0]        p0_radius;

  logic signed [CW-1:0] tlat, tlon, slat, slon, dlat, dlon, dlon_w;
  logic signed [CW-1:0] adlat, adlon, atlat, aslat;
  side_t                side_next;

  logic                vld_line  [0:N-1];
  side_t               side_line [0:N-1];
  logic [RAD_BITS-1:0] mag [0:3];
  logic                neg [0:3];

  logic signed [CW-1:0] rad [0:3];
  logic signed [CW-1:0] sn [0:3];
  logic signed [CW-1:0] cs [0:3];
  logic [60:0]          va, vb;
  logic [SQ_BITS-1:0]   ry, rx;
  logic signed [CW-1:0] zang;
  logic [30:0]          zc;
  logic [54:0]          prod;
  logic [55:0]          psum;
  logic [25:0]          dist_raw;
  logic [24:0]          dist_sat;

  logic        out_vld;
  logic [1:0]  status;
  logic [24:0] distance;

  assign en = !out_vld || result.ready;
  assign request.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_radius <= RADIUS_RESET;
    end else if (cfg_we) begin
      default_radius <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_vld  <= 1'b0;
      out_vld <= 1'b0;
      for (int k = 0; k < N; k++) vld_line[k] <= 1'b0;
    end else if (en) begin
      p0_vld      <= request.valid;
      vld_line[0] <= p0_vld;
      for (int k = 1; k < N; k++) vld_line[k] <= vld_line[k-1];
      out_vld     <= vld_line[N-1];
    end
  end

  always_comb begin
    tlat = CW'(p0_tlat);
    tlon = CW'(p0_tlon);
    slat = CW'(p0_slat);
    slon = CW'(p0_slon);
    if (slat > LAT_LIMIT) slat = LAT_LIMIT;
    else if (slat < -LAT_LIMIT) slat = -LAT_LIMIT;
    if (slon > LON_LIMIT) slon = LON_LIMIT;
    else if (slon < -LON_LIMIT) slon = -LON_LIMIT;
    dlat = slat - tlat;
    dlon = slon - tlon;
    if (dlon > LON_LIMIT) dlon_w = dlon - LON_TURN;
    else if (dlon < -LON_LIMIT) dlon_w = dlon + LON_TURN;
    else dlon_w = dlon;
    adlat = (dlat < 0) ? -dlat : dlat;
    adlon = (dlon_w < 0) ? -dlon_w : dlon_w;
    atlat = (tlat < 0) ? -tlat : tlat;
    aslat = (slat < 0) ? -slat : slat;
    side_next.invalid = (tlat < -LAT_LIMIT) || (tlat > LAT_LIMIT) ||
                        (tlon < -LON_LIMIT) || (tlon > LON_LIMIT);
    side_next.radius  = p0_rgiven ? p0_radius : default_radius;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_tlat   <= request.target_lat;
      p0_tlon   <= request.target_lon;
      p0_slat   <= request.site_lat;
      p0_slon   <= request.site_lon;
      p0_rgiven <= request.radius_given;
      p0_radius <= request.radius_m;
      mag[0] <= adlat[RAD_BITS-1:0];
      neg[0] <= dlat < 0;
      mag[1] <= adlon[RAD_BITS-1:0];
      neg[1] <= dlon_w < 0;
      mag[2] <= {atlat[RAD_BITS-2:0], 1'b0};
      neg[2] <= tlat < 0;
      mag[3] <= {aslat[RAD_BITS-2:0], 1'b0};
      neg[3] <= slat < 0;
      side_line[0] <= side_next;
      for (int k = 1; k < N; k++) side_line[k] <= side_line[k-1];
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    ghc_div u_div (
      .clk (clk),
      .en  (en),
      .mag (mag[g]),
      .neg (neg[g]),
      .rad (rad[g])
    );

    ghc_cordic #(
      .STAGES    (CORDIC_STAGES),
      .VECTORING (1'b0)
    ) u_sincos (
      .clk   (clk),
      .en    (en),
      .x_in  (INV_GAIN),
      .y_in  ('0),
      .z_in  (rad[g]),
      .x_out (cs[g]),
      .y_out (sn[g]),
      .z_out ()
    );
  end

  ghc_hav u_hav (
    .clk (clk),
    .en  (en),
    .sdl (sn[0][31:0]),
    .sdo (sn[1][31:0]),
    .cl1 (cs[2][31:0]),
    .cl2 (cs[3][31:0]),
    .va  (va),
    .vb  (vb)
  );

  ghc_sqrt u_sqrt_a (
    .clk  (clk),
    .en   (en),
    .v    (va),
    .root (ry)
  );

  ghc_sqrt u_sqrt_b (
    .clk  (clk),
    .en   (en),
    .v    (vb),
    .root (rx)
  );

  ghc_cordic #(
    .STAGES    (CORDIC_STAGES),
    .VECTORING (1'b1)
  ) u_atan (
    .clk   (clk),
    .en    (en),
    .x_in  ($signed({3'b000, rx})),
    .y_in  ($signed({3'b000, ry})),
    .z_in  ('0),
    .x_out (),
    .y_out (),
    .z_out (zang)
  );

  always_comb begin
    if (zang < 0) zc = '0;
    else if (zang > HALF_PI) zc = HALF_PI[30:0];
    else zc = zang[30:0];
    psum     = 56'(prod) + (56'd1 << 29);
    dist_raw = psum[55:30];
    dist_sat = (dist_raw > 26'(DIST_MAX)) ? DIST_MAX : dist_raw[24:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= 55'(zc) * 55'(EARTH_2X);
      if (side_line[N-1].invalid) begin
        status   <= ST_INVALID;
        distance <= '0;
      end else begin
        status   <= (26'(dist_sat) > side_line[N-1].radius) ? ST_OUTSIDE : ST_INSIDE;
        distance <= dist_sat;
      end
    end
  end

  assign result.valid      = out_vld;
  assign result.status     = status;
  assign result.distance_m = distance;

endmodule

>>> hw/rtl/ghc_check.sv
// Port-level assertions for the geofence check unit and their bind.
module ghc_check
  import ghc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [24:0] distance_m
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(distance_m))
    else $error("result changed while stalled");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input ready during output stall");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_INSIDE || status == ST_INVALID || status == ST_OUTSIDE))
    else $error("bad status code");

  a_inval: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_INVALID |-> distance_m == '0)
    else $error("invalid item with nonzero distance");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> distance_m <= DIST_MAX)
    else $error("distance out of range");

endmodule

bind geofence_haversine_check_unit ghc_check u_ghc_check (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (request.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .status     (result.status),
  .distance_m (result.distance_m)
);

>>> tb/tb_geofence_haversine_check_unit.sv
// Self-checking testbench for the geofence haversine distance check unit.
module tb_geofence_haversine_check_unit;
  import ghc_pkg::*;

  localparam int STAGES        = 24;
  localparam int LATENCY       = 41 + 2 * STAGES;
  localparam int STALL_LIMIT   = 5000;
  localparam int RANDOM_ITEMS  = 75;

  typedef struct {
    logic signed [31:0] target_lat;
    logic signed [31:0] target_lon;
    logic signed [30:0] site_lat;
    logic signed [31:0] site_lon;
    logic               radius_given;
    logic [25:0]        radius_m;
  } fix_t;

  typedef struct {
    logic [1:0]  status;
    logic [24:0] distance_m;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [25:0] cfg_wdata = '0;

  ghc_in_if  req_if ();
  ghc_out_if res_if ();

  geofence_haversine_check_unit #(.CORDIC_STAGES(STAGES)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .request   (req_if),
    .result    (res_if)
  );

  always #5 clk = ~clk;

  logic [25:0] model_default_radius = RADIUS_RESET;
  verdict_t    verdict_q[$];
  int          errors = 0;
  int          results_seen = 0;
  int          radius_writes = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          hold_request = 0;
  int          hold_cnt = 0;
  int          quiet_cycles = 0;

  initial begin
    req_if.valid        = 1'b0;
    req_if.target_lat   = '0;
    req_if.target_lon   = '0;
    req_if.site_lat     = '0;
    req_if.site_lon     = '0;
    req_if.radius_given = 1'b0;
    req_if.radius_m     = '0;
    res_if.ready        = 1'b0;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint arctan_step(int i);
    case (i)
      0: return 843314856;
      1: return 497837829;
      2: return 263043837;
      3: return 133525158;
      4: return 67021686;
      5: return 33543515;
      6: return 16775850;
      7: return 8388437;
      8: return 4194282;
      9: return 2097149;
      default: return (i <= 30) ? ((64'sd1 <<< (30 - i)) - 1) : 0;
    endcase
  endfunction

  function automatic longint deg_to_rad(longint d, longint unsigned div);
    longint unsigned mag;
    longint r;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    r = longint'((mag * 64'd3373259426 + div / 2) / div);
    return (d < 0) ? -r : r;
  endfunction

  function automatic void rotate_sincos(input longint ang, output longint s, output longint c);
    longint x, y, z, dx, dy;
    x = 652032874;
    y = 0;
    z = ang;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_step(i);
      end else begin
        x += dx; y -= dy; z += arctan_step(i);
      end
    end
    s = y;
    c = x;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_step(i);
      end else begin
        x -= dx; y += dy; z -= arctan_step(i);
      end
    end
    return z;
  endfunction

  function automatic longint unsigned bit_sqrt(longint unsigned v);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic verdict_t predict_geofence(fix_t f, logic [25:0] dflt);
    verdict_t v;
    longint tlat, tlon, slat, slon, dlon, sdl, cdl, sdo, cdo, sl1, cl1, sl2, cl2;
    longint t, a, z, dist_m;
    logic [25:0] radius;
    tlat = f.target_lat;
    tlon = f.target_lon;
    slat = clip(f.site_lat, -900000000, 900000000);
    slon = clip(f.site_lon, -1800000000, 1800000000);
    radius = f.radius_given ? f.radius_m : dflt;
    if (tlat < -900000000 || tlat > 900000000 || tlon < -1800000000 || tlon > 1800000000) begin
      v.status = ST_INVALID;
      v.distance_m = '0;
      return v;
    end
    dlon = slon - tlon;
    if (dlon > 1800000000) dlon -= 64'sd3600000000;
    else if (dlon < -1800000000) dlon += 64'sd3600000000;
    rotate_sincos(deg_to_rad(slat - tlat, 64'd3600000000), sdl, cdl);
    rotate_sincos(deg_to_rad(dlon, 64'd3600000000), sdo, cdo);
    rotate_sincos(deg_to_rad(tlat, 64'd1800000000), sl1, cl1);
    rotate_sincos(deg_to_rad(slat, 64'd1800000000), sl2, cl2);
    t = (cl1 * cl2) >>> 30;
    a = ((sdl * sdl) >>> 30) + ((t * ((sdo * sdo) >>> 30)) >>> 30);
    a = clip(a, 0, 64'sd1 <<< 30);
    z = vector_angle(longint'(bit_sqrt(longint'(a) << 30)),
                     longint'(bit_sqrt(longint'((64'sd1 <<< 30) - a) << 30)));
    z = clip(z, 0, 1686629713);
    dist_m = clip((2 * z * 6371000 + (64'sd1 <<< 29)) >>> 30, 0, 20015087);
    v.status = (dist_m > longint'(radius)) ? ST_OUTSIDE : ST_INSIDE;
    v.distance_m = dist_m[24:0];
    return v;
  endfunction

  function automatic fix_t make_fix(longint tlat, longint tlon, longint slat, longint slon,
                                    logic given, logic [25:0] rad);
    fix_t f;
    f.target_lat = tlat[31:0];
    f.target_lon = tlon[31:0];
    f.site_lat = slat[30:0];
    f.site_lon = slon[31:0];
    f.radius_given = given;
    f.radius_m = rad;
    return f;
  endfunction

  task automatic send_fix(fix_t f);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.target_lat   <= f.target_lat;
    req_if.target_lon   <= f.target_lon;
    req_if.site_lat     <= f.site_lat;
    req_if.site_lon     <= f.site_lon;
    req_if.radius_given <= f.radius_given;
    req_if.radius_m     <= f.radius_m;
    do @(posedge clk); while (!req_if.ready);
    verdict_q.push_back(predict_geofence(f, model_default_radius));
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_default_radius(logic [25:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    model_default_radius = value;
    radius_writes++;
  endtask

  function automatic fix_t random_fix();
    fix_t f;
    verdict_t v;
    int kind;
    longint d;
    kind = $urandom_range(99);
    if (kind < 10) begin
      f = make_fix($signed($urandom), $signed($urandom), $signed($urandom),
                   $signed($urandom), 1'($urandom_range(1)), 26'($urandom));
    end else begin
      f = make_fix(longint'($urandom_range(1800000000)) - 900000000,
                   longint'($urandom_range(3600000000)) - 1800000000,
                   longint'($urandom_range(1800000000)) - 900000000,
                   longint'($urandom_range(3600000000)) - 1800000000,
                   1'($urandom_range(1)), 26'($urandom));
      if (kind < 40) begin
        f.site_lat = 31'(clip(longint'(f.target_lat) + $urandom_range(2000000) - 1000000,
                              -900000000, 900000000));
        f.site_lon = f.target_lon + $signed($urandom_range(2000000) - 1000000);
      end
      if (kind >= 90) begin
        f.site_lat = 31'($urandom);
        f.site_lon = $urandom;
      end
      if ($urandom_range(1)) begin
        v = predict_geofence(f, model_default_radius);
        d = longint'(v.distance_m) + $urandom_range(2) - 1;
        f.radius_m = 26'(clip(d, 0, 40000000));
      end else if ($urandom_range(1)) begin
        f.radius_m = 26'($urandom_range(40000000));
      end
    end
    return f;
  endfunction

  task automatic run_random(int count, int tx_pct, int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int n = 0; n < count; n++) send_fix(random_fix());
  endtask

  task automatic test_directed();
    fix_t f;
    verdict_t v;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_fix(make_fix(0, 0, 0, 0, 1'b1, 0));
    send_fix(make_fix(900000000, 1800000000, 900000000, 1800000000, 1'b0, 0));
    send_fix(make_fix(-900000000, -1800000000, -900000000, -1800000000, 1'b1, 26'h3FFFFFF));
    send_fix(make_fix(900000001, 0, 0, 0, 1'b1, 0));
    send_fix(make_fix(-900000001, 0, 0, 0, 1'b1, 0));
    send_fix(make_fix(0, 1800000001, 0, 0, 1'b1, 0));
    send_fix(make_fix(0, -1800000001, 0, 0, 1'b1, 0));
    send_fix(make_fix(-2147483648, -2147483648, 0, 0, 1'b0, 0));
    send_fix(make_fix(2147483647, 2147483647, 0, 0, 1'b0, 0));
    send_fix(make_fix(0, 0, 0, 1800000000, 1'b1, 40000000));
    send_fix(make_fix(900000000, 0, -900000000, 0, 1'b1, 0));
    send_fix(make_fix(0, 1799000000, 0, -1799000000, 1'b0, 0));
    send_fix(make_fix(0, -1799000000, 0, 1799000000, 1'b1, 200000));
    send_fix(make_fix(100000000, 0, -1073741824, -2147483648, 1'b1, 0));
    send_fix(make_fix(-100000000, 0, 1073741823, 2147483647, 1'b1, 0));
    send_fix(make_fix(0, 0, 800, 0, 1'b0, 0));
    send_fix(make_fix(0, 0, 80000, 0, 1'b0, 0));
    f = make_fix(123456789, 456789012, 123000000, 456000000, 1'b1, 0);
    v = predict_geofence(f, model_default_radius);
    f.radius_m = 26'(v.distance_m);
    send_fix(f);
    f.radius_m = 26'(v.distance_m) - 26'd1;
    send_fix(f);
    f.radius_given = 1'b0;
    send_fix(f);
    drain();
  endtask

  task automatic test_default_radius();
    write_default_radius(0);
    run_random(15, 0, 0);
    write_default_radius(40000000);
    run_random(15, 0, 0);
    write_default_radius(26'h3FFFFFF);
    run_random(10, 0, 0);
    write_default_radius(26'($urandom_range(40000000)));
    run_random(10, 0, 0);
    write_default_radius(RADIUS_RESET);
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_request = 400;
    for (int n = 0; n < 150; n++) send_fix(random_fix());
    drain();
  endtask

  task automatic test_random_idling();
    run_random(RANDOM_ITEMS, 11, 80);
    write_default_radius(26'($urandom_range(40000000)));
    run_random(RANDOM_ITEMS, 80, 11);
    write_default_radius(26'($urandom_range(5000)));
    run_random(RANDOM_ITEMS, 0, 0);
    drain();
  endtask

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_cnt <= hold_request;
      hold_request <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
    if (rst || hold_request > 0 || hold_cnt > 1) res_if.ready <= 1'b0;
    else res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      results_seen++;
      if (verdict_q.size() == 0) begin
        $error("unexpected result status=%0d distance_m=%0d", res_if.status, res_if.distance_m);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (res_if.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, res_if.status);
          errors++;
        end
        if (res_if.distance_m !== want.distance_m) begin
          $error("distance_m expected %0d actual %0d", want.distance_m, res_if.distance_m);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_default_radius();
    test_backpressure();
    test_random_idling();
    repeat (LATENCY + 10) @(posedge clk);
    $display("Covered %0d results: field extremes, invalid targets, wrap, boundary radius,",
             results_seen);
    $display("%0d default radius writes, a long result stall and three idling mixes.",
             radius_writes);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/ghc_pkg.sv
hw/rtl/ghc_in_if.sv
hw/rtl/ghc_out_if.sv
hw/rtl/ghc_div.sv
hw/rtl/ghc_cordic.sv
hw/rtl/ghc_hav.sv
hw/rtl/ghc_sqrt.sv
hw/rtl/geofence_haversine_check_unit.sv
hw/rtl/ghc_check.sv
tb/tb_geofence_haversine_check_unit.sv
